// ----- rtl/core/imp_pkg.sv -----
// Shared types and constants of the icon mask pixel decoder.
package imp_pkg;

    // Input item kinds carried on s_tuser.
    localparam logic CMD_PALETTE = 1'b0;
    localparam logic CMD_GROUP   = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    // Colour depth codes; the unused code decodes as 8bpp.
    localparam logic [1:0] MODE_1BPP = 2'd0;
    localparam logic [1:0] MODE_4BPP = 2'd1;
    localparam logic [1:0] MODE_8BPP = 2'd2;

    // Pixel kinds held in the output stage.
    localparam logic [1:0] PIX_CLEAR   = 2'd0;
    localparam logic [1:0] PIX_BLACK   = 2'd1;
    localparam logic [1:0] PIX_WHITE   = 2'd2;
    localparam logic [1:0] PIX_PALETTE = 2'd3;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // One classified request passed from the front end to the back end.
    typedef struct packed {
        logic        is_group;
        logic [7:0]  entry_index;
        logic [23:0] rgb;
        logic [7:0]  and_mask;
        logic [63:0] color_bits;
        logic [4:0]  group_column;
        logic [7:0]  row;
        logic        last;
    } imp_op_t;

endpackage

// ----- rtl/core/imp_front.sv -----
// Front end: configuration registers, request intake and group position tracking.
module imp_front
    import imp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,
    input  logic         s_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [3:0]   cfg_data,
    output logic         q_valid,
    input  logic         q_ready,
    output imp_op_t      q_op,
    output logic [1:0]   bits_mode
);

    logic [3:0] width_units_reg, width_units_next;
    logic [3:0] height_units_reg, height_units_next;
    logic [1:0] bits_mode_reg, bits_mode_next;
    logic [4:0] group_column_reg, group_column_next;
    logic [7:0] source_row_reg, source_row_next;

    logic [3:0] width_eff;
    logic [3:0] height_eff;
    logic [4:0] groups;
    logic [7:0] height;
    logic       col_wrap;
    logic       row_wrap;
    logic       accept;

    // A zero size behaves as one unit.
    assign width_eff  = (width_units_reg == 4'd0) ? 4'd1 : width_units_reg;
    assign height_eff = (height_units_reg == 4'd0) ? 4'd1 : height_units_reg;
    assign groups     = {width_eff, 1'b0};
    assign height     = {height_eff, 4'b0000};
    assign col_wrap   = (group_column_reg == groups - 5'd1);
    assign row_wrap   = (source_row_reg == height - 8'd1);

    // Every request goes into the queue; the queue's free space paces intake.
    assign s_tready  = q_ready;
    assign q_valid   = s_tvalid;
    assign accept    = s_tvalid && q_ready;
    assign cfg_ready = 1'b1;
    assign bits_mode = bits_mode_reg;

    // Classify the request and attach its output position.
    always_comb begin
        q_op.is_group     = (s_tuser == CMD_GROUP);
        q_op.entry_index  = s_tdata[7:0];
        q_op.rgb          = {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
        q_op.and_mask     = s_tdata[39:32];
        q_op.color_bits   = s_tdata[103:40];
        q_op.group_column = group_column_reg;
        q_op.row          = height - 8'd1 - source_row_reg;
        q_op.last         = row_wrap && col_wrap;
    end

    // Register writes restart the icon; groups step the column and row.
    always_comb begin
        width_units_next  = width_units_reg;
        height_units_next = height_units_reg;
        bits_mode_next    = bits_mode_reg;
        group_column_next = group_column_reg;
        source_row_next   = source_row_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_WIDTH: begin
                    width_units_next  = cfg_data;
                    group_column_next = 5'd0;
                    source_row_next   = 8'd0;
                end
                REG_HEIGHT: begin
                    height_units_next = cfg_data;
                    group_column_next = 5'd0;
                    source_row_next   = 8'd0;
                end
                REG_MODE: begin
                    bits_mode_next    = cfg_data[1:0];
                    group_column_next = 5'd0;
                    source_row_next   = 8'd0;
                end
                default: begin
                end
            endcase
        end else if (accept && s_tuser == CMD_GROUP) begin
            if (col_wrap) begin
                group_column_next = 5'd0;
                source_row_next   = row_wrap ? 8'd0 : source_row_reg + 8'd1;
            end else begin
                group_column_next = group_column_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_units_reg  <= 4'd2;
            height_units_reg <= 4'd2;
            bits_mode_reg    <= MODE_1BPP;
            group_column_reg <= 5'd0;
            source_row_reg   <= 8'd0;
        end else begin
            width_units_reg  <= width_units_next;
            height_units_reg <= height_units_next;
            bits_mode_reg    <= bits_mode_next;
            group_column_reg <= group_column_next;
            source_row_reg   <= source_row_next;
        end
    end

endmodule

// ----- rtl/core/imp_queue.sv -----
// Two-entry request queue between the front end and the back end.
module imp_queue
    import imp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    wr_valid,
    output logic    wr_ready,
    input  imp_op_t wr_op,
    output logic    rd_valid,
    input  logic    rd_pop,
    output imp_op_t rd_op
);

    imp_op_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_op    = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

// ----- rtl/core/imp_back.sv -----
// Back end: palette memory, per-pixel decode and the result register.
module imp_back
    import imp_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_pop,
    input  imp_op_t     q_op,
    input  logic [1:0]  bits_mode,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    output logic        m_tlast
);

    localparam int ADDR_W = $clog2(PALETTE_DEPTH);

    logic [23:0] palette_mem [PALETTE_DEPTH];
    logic [23:0] rd_data_reg;

    logic [2:0] pix_reg, pix_next;
    logic       b_valid_reg, b_valid_next;
    logic [7:0] b_col_reg;
    logic [7:0] b_row_reg;
    logic       b_last_reg;
    logic [1:0] b_kind_reg;

    logic       advance;
    logic       fire;
    logic       wr_en;
    logic       rd_en;
    logic       issue;
    logic [2:0] pos;
    logic [7:0] pal_index;
    logic       in_range;
    logic [1:0] kind;
    logic [31:0] rgba;

    // The head request moves when the result register is free or draining.
    assign advance = !b_valid_reg || m_tready;
    assign fire    = q_valid && advance;
    assign issue   = fire && q_op.is_group;
    assign q_pop   = fire && (!q_op.is_group || pix_reg == 3'd7);
    assign wr_en   = fire && !q_op.is_group
                     && ({1'b0, q_op.entry_index} < 9'(PALETTE_DEPTH));

    // Pick the current pixel's mask and colour bits; leftmost pixel first.
    assign pos = ~pix_reg;
    always_comb begin
        case (bits_mode)
            MODE_4BPP: pal_index = {4'b0000, q_op.color_bits[{1'b0, pos, 2'b00} +: 4]};
            default:   pal_index = q_op.color_bits[{pos, 3'b000} +: 8];
        endcase
        in_range = ({1'b0, pal_index} < 9'(PALETTE_DEPTH));
        if (q_op.and_mask[pos]) begin
            kind = PIX_CLEAR;
        end else if (bits_mode == MODE_1BPP) begin
            kind = q_op.color_bits[pos] ? PIX_WHITE : PIX_BLACK;
        end else if (in_range) begin
            kind = PIX_PALETTE;
        end else begin
            kind = PIX_BLACK;
        end
    end
    assign rd_en = issue && (kind == PIX_PALETTE);

    // Palette memory with a registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            palette_mem[q_op.entry_index[ADDR_W-1:0]] <= q_op.rgb;
        end
        if (rd_en) begin
            rd_data_reg <= palette_mem[pal_index[ADDR_W-1:0]];
        end
    end

    // Pixel counter and result valid.
    always_comb begin
        pix_next     = issue ? pix_reg + 3'd1 : pix_reg;
        b_valid_next = advance ? issue : b_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_reg     <= 3'd0;
            b_valid_reg <= 1'b0;
        end else begin
            pix_reg     <= pix_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (issue) begin
            b_col_reg  <= {q_op.group_column, pix_reg};
            b_row_reg  <= q_op.row;
            b_last_reg <= q_op.last && (pix_reg == 3'd7);
            b_kind_reg <= kind;
        end
    end

    always_comb begin
        case (b_kind_reg)
            PIX_BLACK:   rgba = {24'h000000, ALPHA_OPAQUE};
            PIX_WHITE:   rgba = {24'hFFFFFF, ALPHA_OPAQUE};
            PIX_PALETTE: rgba = {rd_data_reg, ALPHA_OPAQUE};
            default:     rgba = 32'h00000000;
        endcase
    end

    assign m_tvalid = b_valid_reg;
    assign m_tdata  = {rgba, b_row_reg, b_col_reg};
    assign m_tlast  = b_last_reg;

endmodule

// ----- rtl/core/icon_mask_pixel_decoder.sv -----
// Top level of the icon mask pixel decoder.
// Decodes icon AND/XOR mask data into RGBA pixels, one pixel per cycle on the
// master stream while it is not stalled. A pixel-group request is decoded one
// pixel at a time in the back end, since the result channel carries one pixel and
// the palette memory has one read port. The front end keeps accepting requests
// into a two-entry queue while the back end works. A request is written into a
// queue slot on acceptance, and each pixel of a group at the queue head is then
// registered in the result register. Rows arrive bottom-up and leave numbered
// top-down; tlast marks the final pixel of the icon. A write to the width,
// height or mode register restarts at the first group of the bottom row. There
// is no clearing pass after reset.
module icon_mask_pixel_decoder
    import imp_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
)
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // entry_index, red, green, blue, and_mask, color_bits (lowest bit first)
    input  logic [103:0] s_tdata,
    // command
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // column, row, rgba (lowest bit first)
    output logic [47:0]  m_tdata,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [3:0]   cfg_data
);

    imp_op_t    front_op;
    imp_op_t    head_op;
    logic       front_valid;
    logic       front_ready;
    logic       head_valid;
    logic       head_pop;
    logic [1:0] bits_mode;

    imp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (front_valid),
        .q_ready   (front_ready),
        .q_op      (front_op),
        .bits_mode (bits_mode)
    );

    imp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_op    (front_op),
        .rd_valid (head_valid),
        .rd_pop   (head_pop),
        .rd_op    (head_op)
    );

    imp_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (head_valid),
        .q_pop     (head_pop),
        .q_op      (head_op),
        .bits_mode (bits_mode),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- rtl/core/imp_checker.sv -----
// Port-level checks of the icon mask pixel decoder, bound to the top level.
module imp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Reset empties the result stage.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // The final pixel sits in the top row at the end of a group.
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata[15:8] == 8'd0) && (m_tdata[2:0] == 3'd7))
        else $error("icon end flagged at wrong position");

    // A pixel that is not opaque is fully transparent black.
    a_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[23:16] != 8'hFF) |-> (m_tdata[47:16] == 32'd0))
        else $error("partially transparent pixel");

endmodule

bind icon_mask_pixel_decoder imp_checker u_imp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
